>>> src/fiws_pkg.sv
package fiws_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_WINDOW_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_REPORT_PERIOD = 2'd1;
    localparam logic [1:0] CFG_TICK_RATE     = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_WINDOW_LIMIT  = 8'd100;
    localparam logic [31:0] RST_REPORT_PERIOD = 32'd1000000;
    localparam logic [31:0] RST_TICK_RATE     = 32'd1000000;

    localparam int DIV_W = 64;

    // Start request to the serial divider
    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } t_div_req;

endpackage

>>> src/fiws_ring.sv
module fiws_ring #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wint,
    input  logic [31:0]   i_wfrm,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rint,
    output logic [31:0]   o_rfrm
);

    logic [31:0] r_int_mem [DEPTH];
    logic [31:0] r_frm_mem [DEPTH];

    // One write port, one registered read port per array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_int_mem[i_waddr] <= i_wint;
            r_frm_mem[i_waddr] <= i_wfrm;
        end
        o_rint <= r_int_mem[i_raddr];
        o_rfrm <= r_frm_mem[i_raddr];
    end

endmodule

>>> src/fiws_div.sv
module fiws_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fiws_pkg::t_div_req i_req,
    output logic              o_done,
    output logic [31:0]       o_quot
);
    import fiws_pkg::*;

    logic [DIV_W:0]           r_rem;
    logic [DIV_W-1:0]         r_quo;
    logic [DIV_W-1:0]         r_den;
    logic [$clog2(DIV_W):0]   r_cnt;
    logic                     r_busy;
    logic [DIV_W:0]           n_shift;
    logic [DIV_W:0]           n_diff;

    // One restoring step per cycle
    assign n_shift = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign n_diff  = n_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (!n_diff[DIV_W]) begin
                    r_rem <= n_diff;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ($clog2(DIV_W)+1)'(DIV_W-1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // Zero divisor or a quotient above 32 bits saturates
    assign o_quot = (r_den == '0 || r_quo[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF
                                                           : r_quo[31:0];

endmodule

>>> src/frame_interval_window_stats_unit.sv
// Frame interval window statistics.
// A report walks the window (one ring read per cycle) and then runs the three rate
// divisions in the serial divider (one quotient bit per cycle).
// Throughput: one input per cycle between reports; none accepted while a report is built.
// Reset: synchronous active-low; clears counters and restores register defaults.
module frame_interval_window_stats_unit #(
    parameter int WINDOW_DEPTH = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_timestamp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_first_frame,
    output logic [31:0] o_last_frame,
    output logic [31:0] o_average_rate,
    output logic [31:0] o_worst_rate,
    output logic [31:0] o_best_rate
);
    import fiws_pkg::*;

    localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = FW + 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SETUP, ST_WALK, ST_DSTART, ST_DWAIT, ST_FIN
    } t_state;

    t_state              r_state;
    logic [7:0]          r_wlim;
    logic [31:0]         r_period;
    logic [31:0]         r_tick;
    logic [AW-1:0]       r_head;
    logic [FW-1:0]       r_fill;
    logic [31:0]         r_prev;
    logic                r_seen;
    logic [31:0]         r_fcnt;
    logic signed [33:0]  r_cd;
    logic [AW-1:0]       r_addr;
    logic [FW-1:0]       r_k;
    logic                r_rd_v;
    logic                r_rd_first;
    logic [63:0]         r_sum;
    logic [31:0]         r_max;
    logic [31:0]         r_min;
    logic [31:0]         r_first;
    logic [31:0]         r_last;
    logic [31:0]         r_avg;
    logic [31:0]         r_worst;
    logic [31:0]         r_best;
    logic [1:0]          r_phase;

    logic                accept;
    logic [31:0]         iv;
    logic [15:0]         eff_lim;
    logic [15:0]         fill_inc;
    logic signed [34:0]  cd_sub;
    logic signed [33:0]  cd_sat;
    logic [SW-1:0]       old_tmp;
    logic [AW-1:0]       oldest;
    logic [31:0]         rd_int;
    logic [31:0]         rd_frm;
    logic [FW+31:0]      fill_prod;
    t_div_req            div_req;
    logic                div_done;
    logic [31:0]         div_q;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;
    assign iv      = i_timestamp - r_prev;

    // Effective window limit and next fill
    always_comb begin
        if (r_wlim == '0)
            eff_lim = 16'd1;
        else if (16'(r_wlim) > 16'(WINDOW_DEPTH))
            eff_lim = 16'(WINDOW_DEPTH);
        else
            eff_lim = 16'(r_wlim);
        fill_inc = 16'(r_fill) + 16'd1;
        if (fill_inc > eff_lim)
            fill_inc = eff_lim;
    end

    // Countdown step with saturation at -2^33
    always_comb begin
        cd_sub = 35'(r_cd) - $signed({3'b0, iv});
        if (cd_sub < -35'sd8589934592)
            cd_sat = -34'sd8589934592;
        else
            cd_sat = cd_sub[33:0];
    end

    // Oldest slot from head and fill
    always_comb begin
        old_tmp = SW'(r_head) + SW'(WINDOW_DEPTH) - SW'(r_fill);
        if (old_tmp >= SW'(WINDOW_DEPTH))
            old_tmp = old_tmp - SW'(WINDOW_DEPTH);
        oldest = AW'(old_tmp);
    end

    fiws_ring #(.DEPTH(WINDOW_DEPTH), .AW(AW)) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && r_seen),
        .i_waddr (r_head),
        .i_wint  (iv),
        .i_wfrm  (r_fcnt),
        .i_raddr (r_addr),
        .o_rint  (rd_int),
        .o_rfrm  (rd_frm)
    );

    // Divider operands by phase: average, worst, best
    assign fill_prod = r_fill * r_tick;
    always_comb begin
        div_req.start = (r_state == ST_DSTART);
        case (r_phase)
            2'd0: begin
                div_req.num = 64'(fill_prod) << 8;
                div_req.den = r_sum;
            end
            2'd1: begin
                div_req.num = {24'b0, r_tick, 8'b0};
                div_req.den = 64'(r_max);
            end
            default: begin
                div_req.num = {24'b0, r_tick, 8'b0};
                div_req.den = 64'(r_min);
            end
        endcase
    end

    fiws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlim   <= RST_WINDOW_LIMIT;
            r_period <= RST_REPORT_PERIOD;
            r_tick   <= RST_TICK_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WINDOW_LIMIT:  r_wlim   <= i_cfg_data[7:0];
                CFG_REPORT_PERIOD: r_period <= i_cfg_data;
                CFG_TICK_RATE:     r_tick   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control and report sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_prev  <= '0;
            r_seen  <= 1'b0;
            r_fcnt  <= '0;
            r_cd    <= $signed({2'b0, RST_REPORT_PERIOD});
            r_rd_v  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            // Output taken; ST_FIN handles its own reload
            if (o_valid && i_ready && r_state != ST_FIN)
                o_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_prev <= i_timestamp;
                        r_fcnt <= r_fcnt + 32'd1;
                        r_seen <= 1'b1;
                        if (r_seen) begin
                            r_head <= (r_head == AW'(WINDOW_DEPTH - 1)) ? '0 : r_head + 1'b1;
                            r_fill <= FW'(fill_inc);
                            if (cd_sat <= 0) begin
                                r_cd    <= cd_sat + $signed({2'b0, r_period});
                                r_last  <= r_fcnt;
                                r_state <= ST_SETUP;
                            end else begin
                                r_cd <= cd_sat;
                            end
                        end
                    end
                end
                ST_SETUP: begin
                    r_addr     <= oldest;
                    r_k        <= '0;
                    r_rd_v     <= 1'b0;
                    r_rd_first <= 1'b1;
                    r_sum      <= '0;
                    r_max      <= '0;
                    r_min      <= 32'hFFFF_FFFF;
                    r_state    <= ST_WALK;
                end
                ST_WALK: begin
                    // Issue one read per cycle, fold in its data in the cycle after
                    r_rd_v <= (r_k != r_fill);
                    if (r_k != r_fill) begin
                        r_k    <= r_k + 1'b1;
                        r_addr <= (r_addr == AW'(WINDOW_DEPTH - 1)) ? '0 : r_addr + 1'b1;
                    end
                    if (r_rd_v) begin
                        r_sum <= r_sum + 64'(rd_int);
                        if (rd_int > r_max) r_max <= rd_int;
                        if (rd_int < r_min) r_min <= rd_int;
                        if (r_rd_first) r_first <= rd_frm;
                        r_rd_first <= 1'b0;
                    end
                    if (r_k == r_fill && !r_rd_v) begin
                        r_phase <= 2'd0;
                        r_state <= ST_DSTART;
                    end
                end
                ST_DSTART: begin
                    r_state <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_done) begin
                        case (r_phase)
                            2'd0: begin
                                r_avg   <= div_q;
                                r_phase <= 2'd1;
                                r_state <= ST_DSTART;
                            end
                            2'd1: begin
                                r_worst <= div_q;
                                r_phase <= 2'd2;
                                r_state <= ST_DSTART;
                            end
                            default: begin
                                r_best  <= div_q;
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_FIN: begin
                    // Load output register once the previous report is taken
                    if (!o_valid || i_ready) begin
                        o_valid        <= 1'b1;
                        o_first_frame  <= r_first;
                        o_last_frame   <= r_last;
                        o_average_rate <= r_avg;
                        o_worst_rate   <= r_worst;
                        o_best_rate    <= r_best;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
